FILE: hw/rtl/swa_pkg.sv
// Shared constants and types for the sliding window average block.
`timescale 1ns / 1ps

package swa_pkg;

   // Sizing of the sample history and the arithmetic
   localparam int MAX_WINDOW    = 64;
   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS    = $clog2(MAX_WINDOW + 1);
   localparam int CFG_BITS      = 7;
   localparam int SUM_BITS      = SAMPLE_BITS + SLOT_BITS + 1;
   localparam int DIVIDEND_BITS = SUM_BITS + FRACTION_BITS;
   localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);
   localparam int AVG_BITS      = 24;

   // Stream word widths, padded to whole bytes
   localparam int REQ_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = AVG_BITS + COUNT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Status reported by the serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } swa_div_status_type;

endpackage

FILE: hw/rtl/swa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module swa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/swa_divider.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module swa_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [swa_pkg::DIVIDEND_BITS-1:0]   dividend,
   input  logic [swa_pkg::COUNT_BITS-1:0]      divisor,
   output logic [swa_pkg::DIVIDEND_BITS-1:0]   quotient,
   output swa_pkg::swa_div_status_type         status
);

   localparam int TRIAL_BITS = swa_pkg::COUNT_BITS + 2;

   logic [swa_pkg::DIVIDEND_BITS-1:0] acc_ff, acc_in;
   logic [swa_pkg::COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [swa_pkg::COUNT_BITS-1:0]    divisor_ff, divisor_in;
   logic [swa_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [TRIAL_BITS-1:0]             trial;
   logic                              fits;

   // Shift the next dividend bit into the remainder and try the subtract
   assign trial = {1'b0, rem_ff, acc_ff[swa_pkg::DIVIDEND_BITS-1]}
                - {2'b00, divisor_ff};
   assign fits  = ~trial[TRIAL_BITS-1];

   always_comb begin
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         // Load operands and begin with the top dividend bit
         acc_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = swa_pkg::STEP_BITS'(swa_pkg::DIVIDEND_BITS - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // Advance one quotient bit; the quotient fills the freed low bits
         acc_in = {acc_ff[swa_pkg::DIVIDEND_BITS-2:0], fits};
         rem_in = fits ? trial[swa_pkg::COUNT_BITS-1:0]
                       : {rem_ff[swa_pkg::COUNT_BITS-2:0], acc_ff[swa_pkg::DIVIDEND_BITS-1]};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hw/rtl/sliding_window_average_core.sv
// Top level of the sliding window average: history, running sum and result stage.
// Path from an accepted req word to rsp_tvalid: history read, sum update,
//    divider load, 31 divider steps, result load (held while the output is full).
// A new req word is taken only back in idle, once the one-bit-per-cycle divider
//    has worked through the 31-bit scaled sum and the result is loaded.
// Reset: window size 64, empty history; the history RAM is not swept, the fill
//    count marks which slots hold samples, so no word is refused after reset.
`timescale 1ns / 1ps

module sliding_window_average_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample stream; tdata: sample[15:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [swa_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // Result stream; tdata: average[23:0], samples_in_window[30:24], zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swa_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // Window size register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swa_pkg::CFG_BITS-1:0]         csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [swa_pkg::COUNT_BITS-1:0]      win_ff, win_in;
   logic [swa_pkg::SLOT_BITS-1:0]       slot_ff, slot_in;
   logic [swa_pkg::COUNT_BITS-1:0]      fill_ff, fill_in;
   logic signed [swa_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [swa_pkg::SAMPLE_BITS-1:0]     sample_ff, sample_in;
   logic                                neg_ff, neg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [swa_pkg::AVG_BITS-1:0]        avg_ff, avg_in;
   logic [swa_pkg::COUNT_BITS-1:0]      count_ff, count_in;

   logic                                req_fire;
   logic                                csr_fire;
   logic                                ram_wr_en;
   logic [swa_pkg::SAMPLE_BITS-1:0]     ram_rd_data;
   logic [swa_pkg::SAMPLE_BITS-1:0]     oldest;
   logic [swa_pkg::COUNT_BITS-1:0]      slot_inc;
   logic [swa_pkg::SUM_BITS-1:0]        magnitude;
   logic [swa_pkg::DIVIDEND_BITS-1:0]   dividend;
   logic [swa_pkg::DIVIDEND_BITS-1:0]   quotient;
   logic [swa_pkg::AVG_BITS-1:0]        quot_low;
   logic                                div_start;
   swa_pkg::swa_div_status_type         div_status;

   // Take words only when idle; a pending window write goes first
   assign req_tready = (state_ff == ST_IDLE) & ~csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_fire   = csr_valid & csr_ready;

   // Sample history; read the oldest slot on accept, overwrite it in the following cycle
   assign ram_wr_en = (state_ff == ST_UPDATE);

   swa_ram #(
      .WIDTH (swa_pkg::SAMPLE_BITS),
      .DEPTH (swa_pkg::MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_fire),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // A slot holds a sample only once the window has filled since the last clear
   assign oldest   = (fill_ff == win_ff) ? ram_rd_data : '0;
   assign slot_inc = swa_pkg::COUNT_BITS'(slot_ff) + 1'b1;

   // Scaled magnitude of the running sum for the divider
   assign magnitude = sum_ff[swa_pkg::SUM_BITS-1] ? swa_pkg::SUM_BITS'(-sum_ff)
                                                  : swa_pkg::SUM_BITS'(sum_ff);
   assign dividend  = {magnitude, {swa_pkg::FRACTION_BITS{1'b0}}};
   assign div_start = (state_ff == ST_START);

   swa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (fill_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   assign quot_low = quotient[swa_pkg::AVG_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;
      count_in     = count_ff;

      // Drop the result word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               // Clamp the window size and clear the history
               if (csr_data == '0) begin
                  win_in = swa_pkg::COUNT_BITS'(1);
               end else if (32'(csr_data) > 32'(swa_pkg::MAX_WINDOW)) begin
                  win_in = swa_pkg::COUNT_BITS'(swa_pkg::MAX_WINDOW);
               end else begin
                  win_in = swa_pkg::COUNT_BITS'(csr_data);
               end
               slot_in = '0;
               fill_in = '0;
               sum_in  = '0;
            end else if (req_fire) begin
               sample_in = req_tdata[swa_pkg::SAMPLE_BITS-1:0];
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Replace the oldest sample in the running sum and advance the slot
            sum_in = sum_ff
                   - swa_pkg::SUM_BITS'($signed(oldest))
                   + swa_pkg::SUM_BITS'($signed(sample_ff));
            slot_in = (slot_inc >= win_ff) ? '0 : slot_inc[swa_pkg::SLOT_BITS-1:0];
            if (fill_ff < win_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_START;
         end
         ST_START: begin
            neg_in   = sum_ff[swa_pkg::SUM_BITS-1];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // Load the result word when the output stage is free
            if (!rsp_valid_ff || rsp_tready) begin
               avg_in       = neg_ff ? swa_pkg::AVG_BITS'(-quot_low) : quot_low;
               count_in     = fill_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
      count_ff  <= count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= swa_pkg::COUNT_BITS'(swa_pkg::MAX_WINDOW);
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(swa_pkg::RSP_TDATA_BITS - swa_pkg::RSP_FIELD_BITS){1'b0}},
                        count_ff, avg_ff};

   // Fill count never passes the window
   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_ff)
      else $error("fill count above window size");

   // Write slot stays inside the window
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < 32'(win_ff))
      else $error("write slot outside window");

   // Divider finishes only while the sequencer waits on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

   // A window write leaves an empty history
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && state_ff == ST_IDLE) |=> (fill_ff == '0 && sum_ff == '0 && slot_ff == '0))
      else $error("history not cleared after window write");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the sliding window average core: directed table, then random.
`timescale 1ns / 1ps

module tb_top;

   // Kinds of rows in the directed stimulus table
   typedef enum logic [1:0] {
      ROW_SAMPLE,
      ROW_WINDOW
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           typed;
      int           mean;
      int           count;
   } stim_row_type;

   typedef struct {
      logic [swa_pkg::AVG_BITS-1:0]   average;
      logic [swa_pkg::COUNT_BITS-1:0] count;
   } window_mean_type;

   localparam int DIRECTED_ROWS  = 25;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 100;
   localparam int MAX_GAP        = 19;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 48;
   localparam int SAMPLE_MAX     = 32767;
   localparam int SAMPLE_MIN     = -32768;

   // Sample patterns for the random phases
   localparam int PAT_UNIFORM  = 0;
   localparam int PAT_EXTREMES = 1;
   localparam int PAT_HIGH     = 2;
   localparam int PAT_LOW      = 3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [swa_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [swa_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [swa_pkg::CFG_BITS-1:0]       csr_data = '0;

   // Copy of the filter state
   logic signed [swa_pkg::SAMPLE_BITS-1:0] window_hist [swa_pkg::MAX_WINDOW];
   int unsigned                            next_slot;
   int unsigned                            fill_level;
   longint                                 window_sum;
   logic [swa_pkg::CFG_BITS-1:0]           window_setting;

   window_mean_type expected_means [$];
   int              fail_count   = 0;
   int              hold_request = 0;
   bit              send_quiet   = 1'b0;
   bit              recv_quiet   = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, 0,          1'b1, 0,        1},
      '{ROW_SAMPLE, SAMPLE_MAX, 1'b1, 4194176,  2},
      '{ROW_SAMPLE, SAMPLE_MIN, 1'b1, -85,      3},
      '{ROW_WINDOW, 1,          1'b0, 0,        0},
      '{ROW_SAMPLE, SAMPLE_MIN, 1'b1, -8388608, 1},
      '{ROW_SAMPLE, SAMPLE_MAX, 1'b1, 8388352,  1},
      '{ROW_SAMPLE, 1,          1'b1, 256,      1},
      '{ROW_WINDOW, 0,          1'b0, 0,        0},
      '{ROW_SAMPLE, -1,         1'b1, -256,     1},
      '{ROW_SAMPLE, 5,          1'b1, 1280,     1},
      '{ROW_WINDOW, 2,          1'b0, 0,        0},
      '{ROW_SAMPLE, 3,          1'b0, 0,        0},
      '{ROW_SAMPLE, -4,         1'b0, 0,        0},
      '{ROW_SAMPLE, 7,          1'b0, 0,        0},
      '{ROW_SAMPLE, SAMPLE_MIN, 1'b0, 0,        0},
      '{ROW_SAMPLE, SAMPLE_MIN, 1'b1, -8388608, 2},
      '{ROW_WINDOW, 127,        1'b0, 0,        0},
      '{ROW_SAMPLE, SAMPLE_MAX, 1'b1, 8388352,  1},
      '{ROW_SAMPLE, -1,         1'b0, 0,        0},
      '{ROW_WINDOW, 3,          1'b0, 0,        0},
      '{ROW_SAMPLE, -21846,     1'b0, 0,        0},
      '{ROW_SAMPLE, 21845,      1'b0, 0,        0},
      '{ROW_SAMPLE, 100,        1'b0, 0,        0},
      '{ROW_WINDOW, 64,         1'b0, 0,        0},
      '{ROW_SAMPLE, -2,         1'b1, -512,     1}
   };

   sliding_window_average_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Free-running clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Drop the whole history and restart the fill
   function automatic void clear_window();
      foreach (window_hist[i]) window_hist[i] = '0;
      next_slot  = 0;
      fill_level = 0;
      window_sum = 0;
   endfunction

   // Window size in force; zero counts as one, oversize clamps to the maximum
   function automatic int unsigned span_in_force();
      if (32'(window_setting) == 0) return 1;
      if (32'(window_setting) > swa_pkg::MAX_WINDOW) return swa_pkg::MAX_WINDOW;
      return 32'(window_setting);
   endfunction

   // Push one sample into the state and return the mean it produces
   function automatic window_mean_type slide_window(
      logic signed [swa_pkg::SAMPLE_BITS-1:0] sample);
      int unsigned     span;
      int unsigned     at;
      longint          magnitude;
      longint          quotient;
      longint          mean;
      window_mean_type result;
      span = span_in_force();
      at   = (next_slot >= span) ? 0 : next_slot;
      window_sum = window_sum - window_hist[at] + sample;
      window_hist[at] = sample;
      at++;
      next_slot = (at >= span) ? 0 : at;
      if (fill_level < span) fill_level++;
      magnitude = (window_sum < 0) ? -window_sum : window_sum;
      quotient  = (magnitude << swa_pkg::FRACTION_BITS) / fill_level;
      mean      = (window_sum < 0) ? -quotient : quotient;
      result.average = mean[swa_pkg::AVG_BITS-1:0];
      result.count   = fill_level[swa_pkg::COUNT_BITS-1:0];
      return result;
   endfunction

   // Offer one sample word after a random gap and hold it until taken
   task automatic push_sample(input logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
                              input bit typed, input int mean, input int count);
      int              gap;
      window_mean_type forecast;
      window_mean_type typed_mean;
      gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      forecast = slide_window(sample);
      if (typed) begin
         typed_mean.average = mean[swa_pkg::AVG_BITS-1:0];
         typed_mean.count   = count[swa_pkg::COUNT_BITS-1:0];
         expected_means.push_back(typed_mean);
      end else begin
         expected_means.push_back(forecast);
      end
   endtask

   // Let the block drain, then write the window size
   task automatic write_window(input logic [swa_pkg::CFG_BITS-1:0] setting);
      req_tvalid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= setting;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_setting = setting;
      clear_window();
   endtask

   function automatic logic signed [swa_pkg::SAMPLE_BITS-1:0] draw_sample(input int pattern);
      case (pattern)
         PAT_EXTREMES: begin
            case ($urandom_range(0, 4))
               0: return swa_pkg::SAMPLE_BITS'(SAMPLE_MIN);
               1: return swa_pkg::SAMPLE_BITS'(SAMPLE_MAX);
               2: return swa_pkg::SAMPLE_BITS'(0);
               3: return swa_pkg::SAMPLE_BITS'(-1);
               default: return swa_pkg::SAMPLE_BITS'($urandom);
            endcase
         end
         PAT_HIGH: return $urandom_range(0, 1) ? swa_pkg::SAMPLE_BITS'(SAMPLE_MAX)
                          : swa_pkg::SAMPLE_BITS'(SAMPLE_MAX - $urandom_range(0, 15));
         PAT_LOW:  return $urandom_range(0, 1) ? swa_pkg::SAMPLE_BITS'(SAMPLE_MIN)
                          : swa_pkg::SAMPLE_BITS'(SAMPLE_MIN + $urandom_range(0, 15));
         default:  return swa_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Compare one result word with the oldest expected mean
   task automatic check_mean(input logic [swa_pkg::RSP_TDATA_BITS-1:0] word);
      window_mean_type                want;
      logic [swa_pkg::AVG_BITS-1:0]   got_average;
      logic [swa_pkg::COUNT_BITS-1:0] got_count;
      got_average = word[swa_pkg::AVG_BITS-1:0];
      got_count   = word[swa_pkg::AVG_BITS +: swa_pkg::COUNT_BITS];
      if (expected_means.size() == 0) begin
         $error("unexpected rsp word %h", word);
         fail_count++;
      end else begin
         want = expected_means.pop_front();
         if (got_average !== want.average) begin
            $error("average: expected %0d, got %0d",
                   $signed(want.average), $signed(got_average));
            fail_count++;
         end
         if (got_count !== want.count) begin
            $error("samples_in_window: expected %0d, got %0d", want.count, got_count);
            fail_count++;
         end
         if (word[swa_pkg::RSP_TDATA_BITS-1:swa_pkg::RSP_FIELD_BITS] !== '0) begin
            $error("pad: expected 0, got %h",
                   word[swa_pkg::RSP_TDATA_BITS-1:swa_pkg::RSP_FIELD_BITS]);
            fail_count++;
         end
      end
   endtask

   // Result side: stall at random, hold off when asked, check each word
   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_mean(rsp_tdata);
         taken++;
         if (taken % 40 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // Guard against a hung handshake
   initial begin
      #4_000_000;
      $display("sliding_window_average_core test failed");
      $finish;
   end

   // Stimulus: reset, directed table, random phases, drain
   initial begin
      int window_list [8] = '{64, 127, 1, 0, 2, 5, 65, 64};
      int pattern_head;
      int pattern_tail;
      logic [swa_pkg::CFG_BITS-1:0] setting;
      window_setting = swa_pkg::CFG_BITS'(swa_pkg::MAX_WINDOW);
      clear_window();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WINDOW)
            write_window(directed_rows[i].value[swa_pkg::CFG_BITS-1:0]);
         else
            push_sample(directed_rows[i].value[swa_pkg::SAMPLE_BITS-1:0],
                        directed_rows[i].typed,
                        directed_rows[i].mean, directed_rows[i].count);
      end

      // Random phases, one window setting each
      for (int phase = 0; phase < PHASES; phase++) begin
         setting = (phase < 8) ? swa_pkg::CFG_BITS'(window_list[phase])
                               : swa_pkg::CFG_BITS'($urandom_range(0, 127));
         write_window(setting);
         send_quiet   = ($urandom_range(0, 3) == 0);
         pattern_head = $urandom_range(PAT_UNIFORM, PAT_LOW);
         pattern_tail = $urandom_range(PAT_UNIFORM, PAT_LOW);
         if (phase == 0) pattern_head = PAT_HIGH;
         if (phase == 1) pattern_head = PAT_LOW;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // back up the result side while samples keep coming
            if (phase == 2 && n == 30) hold_request = HOLD_CYCLES;
            push_sample(draw_sample((n < 70) ? pattern_head : pattern_tail), 1'b0, 0, 0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("sliding_window_average_core test passed");
      else
         $display("sliding_window_average_core test failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/swa_pkg.sv
hw/rtl/swa_ram.sv
hw/rtl/swa_divider.sv
hw/rtl/sliding_window_average_core.sv
dv/tb_top.sv
